>>> sv/iss_pkg.sv
// ----------------------------------------------------------------------------
// iss_pkg
// Shared constants and types for the integer sequence sorter: data width,
// default capacity, the slot carried between cells and the per-cycle command
// that the controller drives into every cell of the chain.
// ----------------------------------------------------------------------------
package iss_pkg;

   localparam int ISS_DATA_W    = 32;
   localparam int ISS_MAX_ITEMS = 64;

   // one stored or travelling element
   typedef struct packed {
      logic                         valid;
      logic signed [ISS_DATA_W-1:0] value;
   } slot_type;

   // command broadcast to every cell
   typedef struct packed {
      logic load;
      logic shift_left;
      logic shift_right;
   } ctrl_type;

endpackage

>>> sv/iss_cell.sv
// ----------------------------------------------------------------------------
// iss_cell
// One cell of the insertion chain. While loading it keeps the smaller of its
// held element and the arriving one and hands the other to the right. While
// draining it takes the held element of its right or left neighbor.
// ----------------------------------------------------------------------------
module iss_cell
   import iss_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  ctrl_type ctrl,
   input  slot_type arrive,
   input  slot_type left_held,
   input  slot_type right_held,
   output slot_type held,
   output slot_type pass
);

   slot_type held_ff, held_in;
   slot_type pass_ff, pass_in;

   // compare and swap, or shift along the chain
   always_comb begin
      held_in       = held_ff;
      pass_in       = pass_ff;
      pass_in.valid = 1'b0;
      priority if (ctrl.load) begin
         if (arrive.valid) begin
            if (!held_ff.valid) begin
               held_in = arrive;
            end else if (arrive.value < held_ff.value) begin
               held_in = arrive;
               pass_in = held_ff;
            end else begin
               pass_in = arrive;
            end
         end
      end else if (ctrl.shift_left) begin
         held_in = right_held;
      end else if (ctrl.shift_right) begin
         held_in = left_held;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff.valid <= 1'b0;
         pass_ff.valid <= 1'b0;
      end else begin
         held_ff <= held_in;
         pass_ff <= pass_in;
      end
   end

   assign held = held_ff;
   assign pass = pass_ff;

endmodule

>>> sv/integer_sequence_sorter_core.sv
// ----------------------------------------------------------------------------
// integer_sequence_sorter_core
// Collects signed 32-bit values into a chain of MAX_ITEMS insertion cells and
// emits the set in ascending or descending order after the closing beat.
// ----------------------------------------------------------------------------
// Usage: while busy is low the block takes one value beat per cycle; each
// beat enters the first cell and ripples right one cell per cycle, so the
// chain stays sorted ascending. Beats beyond MAX_ITEMS are dropped and flag
// overflow on every result of the set. After the beat marked is_last, busy
// stays high while the chain settles and then through the drain, which
// emits one result per cycle on rsp_valid, each in the cycle after its drain
// cycle: ascending drains the stored values from the head cell, descending
// drains from the tail cell, and its drain cycles before the first stored
// value reaches the tail give nothing. Busy falls in the cycle that presents
// the final result.
// The receiver cannot stall: each result beat is present for one cycle only.
// The descending bit is read while the set is emitted.
// ----------------------------------------------------------------------------
module integer_sequence_sorter_core
   import iss_pkg::*;
#(
   parameter int MAX_ITEMS = ISS_MAX_ITEMS
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         start,
   output logic                         busy,
   input  logic signed [ISS_DATA_W-1:0] req_value,
   input  logic                         req_is_last,
   // result channel
   output logic                         rsp_valid,
   output logic signed [ISS_DATA_W-1:0] rsp_sorted_value,
   output logic                         rsp_last_out,
   output logic                         rsp_overflow,
   // configuration channel
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic                         csr_descending
);

   localparam int CNT_W = $clog2(MAX_ITEMS + 1);

   typedef enum logic [2:0] {
      S_LOAD   = 3'b001,
      S_SETTLE = 3'b010,
      S_DRAIN  = 3'b100
   } state_type;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        timer_ff, timer_in;
   logic                    overflowed_ff, overflowed_in;
   logic                    descending_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [ISS_DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic                    rsp_ovf_ff, rsp_ovf_in;

   ctrl_type                ctrl;
   slot_type                held  [MAX_ITEMS];
   slot_type                pass  [MAX_ITEMS];
   slot_type                arrive_head;
   slot_type                empty_slot;
   logic                    accept;
   logic                    full;
   logic                    emit;

   assign accept = start && (state_ff == S_LOAD);
   assign full   = (count_ff == CNT_W'(MAX_ITEMS));

   // configuration register, always ready
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         descending_ff <= 1'b0;
      end else if (csr_valid) begin
         descending_ff <= csr_descending;
      end
   end

   // head of chain takes the request beat unless the store is full
   assign empty_slot.valid  = 1'b0;
   assign empty_slot.value  = '0;
   assign arrive_head.valid = accept && !full;
   assign arrive_head.value = req_value;

   // broadcast command to the cells
   assign ctrl.load        = (state_ff == S_LOAD) || (state_ff == S_SETTLE);
   assign ctrl.shift_left  = (state_ff == S_DRAIN) && !descending_ff;
   assign ctrl.shift_right = (state_ff == S_DRAIN) && descending_ff;

   // build the chain
   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      slot_type arrive_i, left_i, right_i;
      if (i == 0) begin : g_head
         assign arrive_i = arrive_head;
         assign left_i   = empty_slot;
      end else begin : g_body
         assign arrive_i = pass[i-1];
         assign left_i   = held[i-1];
      end
      if (i == MAX_ITEMS - 1) begin : g_tail
         assign right_i = empty_slot;
      end else begin : g_inner
         assign right_i = held[i+1];
      end
      iss_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .arrive     (arrive_i),
         .left_held  (left_i),
         .right_held (right_i),
         .held       (held[i]),
         .pass       (pass[i])
      );
   end

   // ascending drains the head every cycle, descending waits for the tail
   assign emit = (state_ff == S_DRAIN) && (!descending_ff || held[MAX_ITEMS-1].valid);

   // sequence load, settle and drain
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      timer_in      = timer_ff;
      overflowed_in = overflowed_ff;
      rsp_valid_in  = 1'b0;
      rsp_value_in  = descending_ff ? held[MAX_ITEMS-1].value : held[0].value;
      rsp_last_in   = (count_ff == CNT_W'(1));
      rsp_ovf_in    = overflowed_ff;
      unique case (state_ff)
         S_LOAD: begin
            if (accept) begin
               if (full) begin
                  overflowed_in = 1'b1;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
               if (req_is_last) begin
                  timer_in = CNT_W'(MAX_ITEMS);
                  state_in = S_SETTLE;
               end
            end
         end
         S_SETTLE: begin
            timer_in = timer_ff - CNT_W'(1);
            if (timer_ff == CNT_W'(1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (emit) begin
               rsp_valid_in = 1'b1;
               count_in     = count_ff - CNT_W'(1);
               if (count_ff == CNT_W'(1)) begin
                  overflowed_in = 1'b0;
                  state_in      = S_LOAD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_LOAD;
         count_ff      <= '0;
         timer_ff      <= '0;
         overflowed_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         timer_ff      <= timer_in;
         overflowed_ff <= overflowed_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign busy             = (state_ff != S_LOAD);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_last_out     = rsp_last_ff;
   assign rsp_overflow     = rsp_ovf_ff;

   // a result beat only follows a drain cycle
   a_rsp_from_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == S_DRAIN))
      else $error("result beat outside drain");

   // the fill count never passes capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ITEMS))
      else $error("item count beyond capacity");

   // the closing result is followed by a quiet cycle
   a_last_then_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_out) |=> !rsp_valid)
      else $error("result after closing beat");

   // ascending drain always finds a stored element at the head
   a_head_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DRAIN && !descending_ff) |-> held[0].valid)
      else $error("head cell empty during drain");

endmodule

>>> bench/sorted_run_checker.sv
// ----------------------------------------------------------------------------
// sorted_run_checker
// Watches the request, result and configuration channels of the integer
// sequence sorter. It keeps its own copy of the collected set, orders it when
// the closing beat is accepted and compares every result beat with the
// oldest predicted one.
// ----------------------------------------------------------------------------
module sorted_run_checker
   import iss_pkg::*;
#(
   parameter int MAX_ITEMS = ISS_MAX_ITEMS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  logic signed [ISS_DATA_W-1:0] req_value,
   input  logic                         req_is_last,
   input  logic                         rsp_valid,
   input  logic signed [ISS_DATA_W-1:0] rsp_sorted_value,
   input  logic                         rsp_last_out,
   input  logic                         rsp_overflow,
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic                         csr_descending,
   output int                           mismatch_count,
   output int                           pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [ISS_DATA_W-1:0] value;
      logic                         last;
      logic                         overflow;
   } sorted_beat_type;

   // values collected for the open set, in arrival order
   logic signed [ISS_DATA_W-1:0] held_values[$];
   logic                         set_overflowed = 1'b0;
   logic                         order_descending = 1'b0;
   sorted_beat_type              sorted_run[$];
   int                           errors = 0;

   // true if a belongs ahead of b in the current order
   function automatic logic precedes(input logic signed [ISS_DATA_W-1:0] a,
                                     input logic signed [ISS_DATA_W-1:0] b);
      return order_descending ? (a > b) : (a < b);
   endfunction

   // order the held set and queue one result beat per stored value
   function automatic void close_set();
      logic signed [ISS_DATA_W-1:0] ordered[$];
      sorted_beat_type              beat;
      int                           pos;
      foreach (held_values[i]) begin
         pos = 0;
         while (pos < ordered.size() && !precedes(held_values[i], ordered[pos]))
            pos++;
         ordered.insert(pos, held_values[i]);
      end
      foreach (ordered[i]) begin
         beat.value    = ordered[i];
         beat.last     = (i == ordered.size() - 1);
         beat.overflow = set_overflowed;
         sorted_run.push_back(beat);
      end
      held_values.delete();
      set_overflowed = 1'b0;
   endfunction

   always @(posedge clock) begin : watch
      sorted_beat_type beat;
      if (reset) begin
         held_values.delete();
         set_overflowed   = 1'b0;
         order_descending = 1'b0;
      end else begin
         // compare a result beat with the oldest prediction
         if (rsp_valid) begin
            if (sorted_run.size() == 0) begin
               $display("%0t: result beat with nothing expected, got value %0d %s",
                        $time, rsp_sorted_value,
                        $sformatf("last %0b overflow %0b", rsp_last_out, rsp_overflow));
               errors++;
            end else begin
               beat = sorted_run.pop_front();
               if (rsp_sorted_value !== beat.value || rsp_last_out !== beat.last ||
                   rsp_overflow !== beat.overflow) begin
                  $display("%0t: mismatch, expected value %0d last %0b overflow %0b, %s",
                           $time, beat.value, beat.last, beat.overflow,
                           $sformatf("got value %0d last %0b overflow %0b",
                                     rsp_sorted_value, rsp_last_out, rsp_overflow));
                  errors++;
               end
            end
         end
         // track the order bit
         if (csr_valid && csr_ready)
            order_descending = csr_descending;
         // store or drop the accepted beat, close the set on its last beat
         if (start && !busy) begin
            if (held_values.size() < MAX_ITEMS)
               held_values.push_back(req_value);
            else
               set_overflowed = 1'b1;
            if (req_is_last)
               close_set();
         end
      end
      mismatch_count <= errors;
      pending_count  <= sorted_run.size();
   end

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives sets of signed values into the integer sequence sorter in both
// orders, with sets that fill and overflow the store and random gaps between
// beats, and reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module testbench
   import iss_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int   SET_CAPACITY     = ISS_MAX_ITEMS;
   localparam int   SETTLE_CYCLES    = 3 * SET_CAPACITY + 20;
   localparam int   CYCLE_LIMIT      = 400000;
   localparam int   PHASE_ITEMS      = 50;
   localparam logic ORDER_ASCENDING  = 1'b0;
   localparam logic ORDER_DESCENDING = 1'b1;

   logic                         clock;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic signed [ISS_DATA_W-1:0] req_value = '0;
   logic                         req_is_last = 1'b0;
   logic                         rsp_valid;
   logic signed [ISS_DATA_W-1:0] rsp_sorted_value;
   logic                         rsp_last_out;
   logic                         rsp_overflow;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic                         csr_descending = 1'b0;
   int                           mismatch_count;
   int                           pending_count;
   int                           cycle_count = 0;

   // extremes, signs and duplicates for the directed sets
   logic signed [ISS_DATA_W-1:0] edge_set [8] = '{32'sh7FFF_FFFF, 32'sh8000_0000, 0, -1, 1,
                                                  32'sh8000_0000, 32'sh7FFF_FFFF, 5};

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   integer_sequence_sorter_core dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_value        (req_value),
      .req_is_last      (req_is_last),
      .rsp_valid        (rsp_valid),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_last_out     (rsp_last_out),
      .rsp_overflow     (rsp_overflow),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_descending   (csr_descending)
   );

   sorted_run_checker #(.MAX_ITEMS(SET_CAPACITY)) run_check (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_value        (req_value),
      .req_is_last      (req_is_last),
      .rsp_valid        (rsp_valid),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_last_out     (rsp_last_out),
      .rsp_overflow     (rsp_overflow),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_descending   (csr_descending),
      .mismatch_count   (mismatch_count),
      .pending_count    (pending_count)
   );

   // stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // mix of full-range values, values near the extremes and small duplicates
   function automatic logic signed [ISS_DATA_W-1:0] pick_value();
      case ($urandom_range(0, 5))
         0:       return $signed(32'h7FFF_FFFF - $urandom_range(0, 2));
         1:       return $signed(32'h8000_0000 + $urandom_range(0, 2));
         2:       return $signed($urandom_range(0, 8)) - 4;
         default: return $signed($urandom());
      endcase
   endfunction

   // hold start low for the gap, then present the beat until an edge with
   // busy low takes it; busy is sampled mid-cycle, where it is settled
   task automatic send_item(input logic signed [ISS_DATA_W-1:0] value,
                            input logic last, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_value   <= value;
      req_is_last <= last;
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
   endtask

   // one set of random values; some sets go back to back
   task automatic send_set(input int count);
      logic burst;
      int   gap;
      burst = ($urandom_range(0, 2) == 0);
      for (int i = 0; i < count; i++) begin
         gap = burst ? 0 : $urandom_range(0, 18);
         send_item(pick_value(), i == count - 1, gap);
      end
   endtask

   task automatic send_edge_set();
      foreach (edge_set[i])
         send_item(edge_set[i], i == 7, $urandom_range(0, 3));
   endtask

   // wait until every predicted beat has come, then let the block settle
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_order(input logic order);
      csr_valid      <= 1'b1;
      csr_descending <= order;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int size;
      int sent;
      int pick;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes and a one-value set in each order
      write_order(ORDER_ASCENDING);
      send_edge_set();
      send_item(-7, 1'b1, 0);
      drain_results();
      write_order(ORDER_DESCENDING);
      send_edge_set();
      send_item(32'sh8000_0000, 1'b1, 0);

      // random phases, order changed only while idle
      for (int phase = 0; phase < 4; phase++) begin
         drain_results();
         if (phase == 0)
            write_order(ORDER_ASCENDING);
         else if (phase == 1)
            write_order(ORDER_DESCENDING);
         else
            write_order(1'($urandom_range(0, 1)));
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick < 8)
               size = $urandom_range(1, 10);
            else if (pick == 8)
               size = $urandom_range(SET_CAPACITY - 2, SET_CAPACITY);
            else
               size = $urandom_range(SET_CAPACITY + 1, SET_CAPACITY + 6);
            send_set(size);
            sent += size;
         end
      end
      drain_results();

      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
